/* hw/rtl/drs_pkg.sv */
// Shared types and constants of the decimal radix sorter.
// No dependencies; drs_bin2bcd and the top level import it.
package drs_pkg;

	localparam int RADIX      = 10;
	localparam int DIGIT_W    = 4;
	localparam int LAST_DIGIT = RADIX - 1;

	typedef logic [DIGIT_W-1:0] digit_t;

	// Number of decimal digits needed for the largest value of the given width.
	function automatic int dec_digits(int bits);
		longint unsigned v;
		int              n;
		int              k;
		v = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
		n = 0;
		for (k = 0; k < 20; k++) begin
			if (v != 0) begin
				n++;
				v = v / 10;
			end
		end
		return (n < 1) ? 1 : n;
	endfunction

endpackage

/* hw/rtl/drs_in_if.sv */
// Input channel of the decimal radix sorter: valid/ready with value and last.
// Stands alone; the width follows the VALUE_BITS parameter.
interface drs_in_if #(
	parameter int VALUE_BITS = 31
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

/* hw/rtl/drs_out_if.sv */
// Result channel of the decimal radix sorter: valid/ready with the sorted value
// and its flags. Stands alone; the width follows the VALUE_BITS parameter.
interface drs_out_if #(
	parameter int VALUE_BITS = 31
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] sorted_value;
	logic                  final_res;
	logic                  overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

/* hw/rtl/drs_bin2bcd.sv */
// Iterative binary to BCD converter (shift and add three), one bit per cycle.
// Depends on drs_pkg for the digit count and digit width.
module drs_bin2bcd #(
	parameter int VALUE_BITS = 31,
	localparam int DIGITS = drs_pkg::dec_digits(VALUE_BITS),
	localparam int BCD_W = DIGITS * drs_pkg::DIGIT_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] bin,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);
	import drs_pkg::*;

	localparam int STEP_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	// Bias every digit of five or more before the shift carries it over.
	always_comb begin
		for (int k = 0; k < DIGITS; k++) begin
			if (bcd_q[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

/* hw/rtl/decimal_radix_sorter_unit.sv */
// Top level of the decimal radix sorter: load, LSD radix sort over two banks, emit.
// Depends on drs_pkg, drs_in_if, drs_out_if and drs_bin2bcd.
//
//   channel  | dir | payload                           | request moves
//   ---------+-----+-----------------------------------+------------------------------
//   items    | in  | value, last                       | one value; last starts sort
//   results  | out | sorted_value, final_res, overflow | one sorted value of the set
//
// Load: a stored value goes through the bit-serial BCD conversion before it is
// written; a dropped value is not stored. Sort: per decimal digit of the set maximum
// one pass (count sweep, nine-step prefix, scatter sweep), bounded by the single
// read port of the banks. Emit: each result is read from its bank, then loaded
// into the output register. Reset clears all control state and the digit counts
// at once; there is no clearing pass. A stalled result holds the emit sweep; the
// final result may wait while the next set loads.
module decimal_radix_sorter_unit #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	drs_in_if.sink    items,
	drs_out_if.source results
);
	import drs_pkg::*;

	localparam int DIGITS = dec_digits(VALUE_BITS);
	localparam int BCD_W  = DIGITS * DIGIT_W;
	localparam int ENT_W  = VALUE_BITS + BCD_W;
	localparam int AW     = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int PASS_W = $clog2(DIGITS + 1);

	typedef enum logic [7:0] {
		ST_LOAD    = 8'b0000_0001,
		ST_CONV    = 8'b0000_0010,
		ST_SORT    = 8'b0000_0100,
		ST_COUNT   = 8'b0000_1000,
		ST_PREFIX  = 8'b0001_0000,
		ST_SCATTER = 8'b0010_0000,
		ST_EMIT_RD = 8'b0100_0000,
		ST_EMIT_WT = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      item_cnt_q;
	logic                  drop_q;
	logic                  last_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] max_q;
	logic [BCD_W-1:0]      max_bcd_q;
	logic                  src_q;
	logic [PASS_W-1:0]     pass_q;
	logic [PASS_W-1:0]     npass;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  rd_v_s1;
	digit_t                pk_q;
	digit_t                pk_prev;
	logic [AW-1:0]         em_idx_q;
	logic [CNT_W-1:0]      cnt_q [RADIX];

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_final_q;
	logic                  out_over_q;

	logic [ENT_W-1:0]      mem_a [MAX_ITEMS];
	logic [ENT_W-1:0]      mem_b [MAX_ITEMS];
	logic [ENT_W-1:0]      rd_a_q;
	logic [ENT_W-1:0]      rd_b_q;
	logic [ENT_W-1:0]      src_data;
	logic [AW-1:0]         rd_addr;
	logic [CNT_W-1:0]      rd_dec;
	logic                  wr_en;
	logic                  wr_bank;
	logic [AW-1:0]         wr_addr;
	logic [ENT_W-1:0]      wr_data;

	logic                  full;
	logic                  accept;
	logic                  conv_start;
	logic                  conv_done;
	logic [BCD_W-1:0]      conv_bcd;
	logic                  issue;
	digit_t                dig;
	logic [CNT_W-1:0]      slot;
	logic                  is_final;

	drs_bin2bcd #(
		.VALUE_BITS (VALUE_BITS)
	) u_bin2bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.bin    (val_q),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	assign full       = (item_cnt_q == CNT_W'(MAX_ITEMS));
	assign accept     = (state_q == ST_LOAD) && items.valid;
	// start the converter once, in the first cycle after the request is taken
	assign conv_start = (state_q == ST_CONV) && rd_v_s1;
	assign src_data   = src_q ? rd_b_q : rd_a_q;
	assign rd_dec     = rd_idx_q - CNT_W'(1);
	assign pk_prev    = pk_q - DIGIT_W'(1);
	assign is_final   = ((CNT_W'(em_idx_q) + CNT_W'(1)) == item_cnt_q);

	// Passes: one per decimal digit of the maximum, up to its top nonzero digit.
	always_comb begin
		npass = '0;
		for (int k = 0; k < DIGITS; k++) begin
			if (max_bcd_q[k*DIGIT_W +: DIGIT_W] != '0) begin
				npass = PASS_W'(k + 1);
			end
		end
	end

	always_comb begin
		dig = '0;
		for (int k = 0; k < DIGITS; k++) begin
			if (pass_q == PASS_W'(k)) begin
				dig = src_data[k*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign slot = cnt_q[dig] - CNT_W'(1);

	always_comb begin
		issue   = 1'b0;
		rd_addr = em_idx_q;
		case (state_q)
			ST_COUNT: begin
				issue   = (rd_idx_q != item_cnt_q);
				rd_addr = rd_idx_q[AW-1:0];
			end
			ST_SCATTER: begin
				issue   = (rd_idx_q != '0);
				rd_addr = rd_dec[AW-1:0];
			end
			default: begin
				issue   = 1'b0;
				rd_addr = em_idx_q;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_SCATTER) begin
			wr_en   = rd_v_s1;
			wr_bank = ~src_q;
			wr_addr = slot[AW-1:0];
			wr_data = src_data;
		end else begin
			wr_en   = (state_q == ST_CONV) && conv_done;
			wr_bank = 1'b0;
			wr_addr = item_cnt_q[AW-1:0];
			wr_data = {val_q, conv_bcd};
		end
	end

	// Two banks: loads fill bank A, each pass scatters from the source to the other.
	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (wr_en && wr_bank) begin
			mem_b[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_a[rd_addr];
		rd_b_q <= mem_b[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			item_cnt_q  <= '0;
			drop_q      <= 1'b0;
			last_q      <= 1'b0;
			max_q       <= '0;
			max_bcd_q   <= '0;
			src_q       <= 1'b0;
			pass_q      <= '0;
			rd_idx_q    <= '0;
			rd_v_s1     <= 1'b0;
			pk_q        <= '0;
			em_idx_q    <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < RADIX; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						last_q <= items.last;
						if (!full) begin
							rd_v_s1 <= 1'b1;
							state_q <= ST_CONV;
						end else begin
							drop_q <= 1'b1;
							if (items.last) begin
								state_q <= ST_SORT;
							end
						end
					end
				end
				ST_CONV: begin
					// rd_v_s1 marks the first cycle, which starts the converter
					rd_v_s1 <= 1'b0;
					if (conv_done) begin
						item_cnt_q <= item_cnt_q + CNT_W'(1);
						if (val_q > max_q) begin
							max_q     <= val_q;
							max_bcd_q <= conv_bcd;
						end
						state_q <= last_q ? ST_SORT : ST_LOAD;
					end
				end
				ST_SORT: begin
					pass_q <= '0;
					if (npass == '0) begin
						em_idx_q <= '0;
						state_q  <= ST_EMIT_RD;
					end else begin
						for (int k = 0; k < RADIX; k++) begin
							cnt_q[k] <= '0;
						end
						rd_idx_q <= '0;
						state_q  <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					rd_v_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (rd_v_s1) begin
						cnt_q[dig] <= cnt_q[dig] + CNT_W'(1);
					end
					if (!issue && !rd_v_s1) begin
						pk_q    <= DIGIT_W'(1);
						state_q <= ST_PREFIX;
					end
				end
				ST_PREFIX: begin
					cnt_q[pk_q] <= cnt_q[pk_q] + cnt_q[pk_prev];
					if (pk_q == DIGIT_W'(LAST_DIGIT)) begin
						pk_q     <= '0;
						rd_idx_q <= item_cnt_q;
						state_q  <= ST_SCATTER;
					end else begin
						pk_q <= pk_q + DIGIT_W'(1);
					end
				end
				ST_SCATTER: begin
					rd_v_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_dec;
					end
					if (rd_v_s1) begin
						cnt_q[dig] <= slot;
					end
					if (!issue && !rd_v_s1) begin
						src_q <= ~src_q;
						if ((pass_q + PASS_W'(1)) == npass) begin
							em_idx_q <= '0;
							state_q  <= ST_EMIT_RD;
						end else begin
							pass_q <= pass_q + PASS_W'(1);
							for (int k = 0; k < RADIX; k++) begin
								cnt_q[k] <= '0;
							end
							rd_idx_q <= '0;
							state_q  <= ST_COUNT;
						end
					end
				end
				ST_EMIT_RD: begin
					// read only once the output register frees up this cycle
					if (!out_valid_q || results.ready) begin
						state_q <= ST_EMIT_WT;
					end
				end
				ST_EMIT_WT: begin
					out_valid_q <= 1'b1;
					if (is_final) begin
						item_cnt_q <= '0;
						drop_q     <= 1'b0;
						max_q      <= '0;
						max_bcd_q  <= '0;
						src_q      <= 1'b0;
						state_q    <= ST_LOAD;
					end else begin
						em_idx_q <= em_idx_q + AW'(1);
						state_q  <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && accept && !full) begin
			val_q <= items.value;
		end
		if (state_q == ST_EMIT_WT) begin
			out_value_q <= src_data[ENT_W-1 -: VALUE_BITS];
			out_final_q <= is_final;
			out_over_q  <= drop_q;
		end
	end

	assign items.ready          = (state_q == ST_LOAD);
	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.final_res    = out_final_q;
	assign results.overflow     = out_over_q;

endmodule
